>>> src/gpme_pkg.sv
// gpme_pkg: shared types and codes for the GF(2) parity matrix engine.
// No dependencies.
package gpme_pkg;

    localparam int REQ_W   = 3;
    localparam int MASK_W  = 8;
    localparam int IN_COEFF_W = 16;
    localparam int ROW_IDX_W = 3;
    localparam int COL_W   = 5;
    localparam int CFG_W   = 4;

    typedef enum logic [2:0] {
        REQ_CLEAR  = 3'd0,
        REQ_APPEND = 3'd1,
        REQ_CNOT   = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_QUERY  = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_INDEX = 2'd2,
        ERR_SAME  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SUM  = 2'd2,
        ST_OUT  = 2'd3
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0]      req_type;
        logic [MASK_W-1:0]     term_mask;
        logic signed [IN_COEFF_W-1:0] term_coeff;
        logic [ROW_IDX_W-1:0]  control_row;
        logic [ROW_IDX_W-1:0]  target_row;
        logic [COL_W-1:0]      column_index;
    } req_item_t;

    typedef struct packed {
        logic        goal_reached;
        logic [7:0]  total_ones;
        logic [7:0]  term_ones;
        logic [4:0]  terms_left;
        logic        column_one_hot;
        logic [3:0]  one_hot_row;
        logic signed [15:0] removed_coeff;
        logic [1:0]  error_code;
    } rsp_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic sum;
    } cmd_t;

endpackage

>>> src/gpme_ctrl.sv
// gpme_ctrl: sequencer for one transaction: load, execute, summarize, hold result.
// Depends on gpme_pkg.
module gpme_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output gpme_pkg::cmd_t  cmd
);

    gpme_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gpme_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gpme_pkg::ST_IDLE: if (in_valid) state_next = gpme_pkg::ST_EXEC;
            gpme_pkg::ST_EXEC: state_next = gpme_pkg::ST_SUM;
            gpme_pkg::ST_SUM:  state_next = gpme_pkg::ST_OUT;
            gpme_pkg::ST_OUT:  if (!out_stall) state_next = gpme_pkg::ST_IDLE;
            default:           state_next = gpme_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            gpme_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            gpme_pkg::ST_EXEC: cmd.exec = 1'b1;
            gpme_pkg::ST_SUM:  cmd.sum  = 1'b1;
            gpme_pkg::ST_OUT:  out_valid = 1'b1;
            default: ;
        endcase
    end

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("exec must follow load");
    a_out_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum |=> out_valid)
        else $error("result must follow summary");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while result pending");

endmodule

>>> src/gpme_dp.sv
// gpme_dp: matrix flops, coefficient store, request execution and result summary.
// Depends on gpme_pkg.
module gpme_dp #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_TERMS   = 16,
    parameter int COEFF_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gpme_pkg::cmd_t       cmd,
    input  gpme_pkg::req_item_t  in_item,
    input  logic [gpme_pkg::CFG_W-1:0] cfg_rows,
    output gpme_pkg::rsp_item_t  out_item
);

    localparam int TC_W = $clog2(MAX_TERMS + 1);
    localparam int TI_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int RC_W = $clog2(MAX_ROWS + 1);
    localparam int RI_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MASK_LIM = 8;

    logic [MAX_TERMS-1:0] term_reg [MAX_ROWS];
    logic [MAX_ROWS-1:0]  ident_reg [MAX_ROWS];
    logic [COEFF_WIDTH-1:0] coeff_reg [MAX_TERMS];
    logic [TC_W-1:0]      tc_reg;
    gpme_pkg::req_item_t  req_reg;
    gpme_pkg::rsp_item_t  rsp_reg;

    // effective row count
    logic [5:0] n;
    always_comb
    begin
        if (cfg_rows == 4'd0)
            n = 6'd1;
        else if ({2'b0, cfg_rows} > 6'(MAX_ROWS))
            n = 6'(MAX_ROWS);
        else
            n = {2'b0, cfg_rows};
    end

    logic [6:0] tc_w, col_w, ctl_w, tgt_w;
    assign tc_w  = 7'(tc_reg);
    assign col_w = 7'(req_reg.column_index);
    assign ctl_w = 7'(req_reg.control_row);
    assign tgt_w = 7'(req_reg.target_row);

    logic [MAX_TERMS-1:0] tmask;
    logic [MAX_ROWS-1:0]  nmask;
    always_comb
    begin
        for (int k = 0; k < MAX_TERMS; k++) tmask[k] = (7'(k) < tc_w);
        for (int k = 0; k < MAX_ROWS; k++)  nmask[k] = (6'(k) < n);
    end

    // execution
    logic [1:0] err;
    logic       doclear, doapp, docnot, dorem, doq;
    logic [MAX_TERMS-1:0] sel_term;
    logic [MAX_ROWS-1:0]  sel_ident;
    logic [MAX_ROWS-1:0]  ident_tgt_new;
    logic [MAX_TERMS-1:0] term_ctl_new;
    logic [MAX_ROWS-1:0]  colbits;
    logic [TI_W-1:0] ci, ti;
    logic [RI_W-1:0] ii;
    logic [2:0] ctl_i, tgt_i;

    assign ci = TI_W'(req_reg.column_index);
    assign ti = TI_W'(tc_reg);
    // identity column offset; only meaningful for a legal identity query
    assign ii = RI_W'(col_w - tc_w);
    assign ctl_i = req_reg.control_row;
    assign tgt_i = req_reg.target_row;

    always_comb
    begin
        err = gpme_pkg::ERR_OK;
        doclear = 1'b0; doapp = 1'b0; docnot = 1'b0; dorem = 1'b0; doq = 1'b0;
        case (req_reg.req_type)
            gpme_pkg::REQ_CLEAR:  doclear = 1'b1;
            gpme_pkg::REQ_APPEND:
                if (tc_w >= 7'(MAX_TERMS)) err = gpme_pkg::ERR_FULL;
                else doapp = 1'b1;
            gpme_pkg::REQ_CNOT:
                if (ctl_w >= 7'(n) || tgt_w >= 7'(n)) err = gpme_pkg::ERR_INDEX;
                else if (ctl_w == tgt_w) err = gpme_pkg::ERR_SAME;
                else docnot = 1'b1;
            gpme_pkg::REQ_REMOVE:
                if (col_w >= tc_w) err = gpme_pkg::ERR_INDEX;
                else dorem = 1'b1;
            gpme_pkg::REQ_QUERY:
                if (col_w >= tc_w + 7'(n)) err = gpme_pkg::ERR_INDEX;
                else doq = 1'b1;
            default: err = gpme_pkg::ERR_INDEX;
        endcase
    end

    // row selects use only in-range indices when the op is legal
    always_comb
    begin
        sel_term = '0;
        sel_ident = '0;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            if (r == int'(tgt_i)) sel_term = term_reg[r];
            if (r == int'(ctl_i)) sel_ident = ident_reg[r];
        end
        term_ctl_new  = sel_term & tmask;
        ident_tgt_new = sel_ident & nmask;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            if (col_w < tc_w)
                colbits[r] = term_reg[r][ci] & nmask[r];
            else
                colbits[r] = ident_reg[r][ii] & nmask[r];
        end
    end

    // removal: shift upper bits down one place
    logic [MAX_TERMS-1:0] keep_lo, rem_row [MAX_ROWS];
    always_comb
    begin
        for (int k = 0; k < MAX_TERMS; k++) keep_lo[k] = (TI_W'(k) < ci);
        for (int r = 0; r < MAX_ROWS; r++)
            rem_row[r] = ((term_reg[r] & keep_lo) |
                         ((term_reg[r] >> 1) & ~keep_lo)) & (tmask >> 1);
    end

    // query: first set row and count==1
    logic [3:0] first_row;
    logic       onehot;
    always_comb
    begin
        first_row = 4'(n);
        for (int r = MAX_ROWS - 1; r >= 0; r--)
            if (colbits[r]) first_row = 4'(r);
        onehot = $onehot(colbits);
    end

    // summary over post-step state
    logic [10:0] tones, iones;
    logic        goal;
    always_comb
    begin
        tones = '0;
        iones = '0;
        goal  = (tc_reg == '0);
        for (int r = 0; r < MAX_ROWS; r++)
            if (nmask[r])
            begin
                tones = tones + 11'($countones(term_reg[r] & tmask));
                iones = iones + 11'($countones(ident_reg[r] & nmask));
                if ((ident_reg[r] & nmask) != (MAX_ROWS'(1) << r)) goal = 1'b0;
            end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= '0;
            for (int r = 0; r < MAX_ROWS; r++)
            begin
                term_reg[r]  <= '0;
                ident_reg[r] <= MAX_ROWS'(1) << r;
            end
        end
        else if (cmd.exec)
        begin
            if (doclear)
            begin
                tc_reg <= '0;
                for (int r = 0; r < MAX_ROWS; r++)
                begin
                    term_reg[r]  <= '0;
                    ident_reg[r] <= MAX_ROWS'(1) << r;
                end
            end
            if (doapp)
            begin
                for (int r = 0; r < MAX_ROWS; r++)
                    term_reg[r][ti] <= (r < MASK_LIM) && req_reg.term_mask[r % 8]
                                       && nmask[r];
                tc_reg <= tc_reg + 1'b1;
            end
            if (docnot)
            begin
                for (int r = 0; r < MAX_ROWS; r++)
                begin
                    if (r == int'(ctl_i)) term_reg[r]  <= term_reg[r] ^ term_ctl_new;
                    if (r == int'(tgt_i)) ident_reg[r] <= ident_reg[r] ^ ident_tgt_new;
                end
            end
            if (dorem)
            begin
                for (int r = 0; r < MAX_ROWS; r++) term_reg[r] <= rem_row[r];
                tc_reg <= tc_reg - 1'b1;
            end
        end
    end

    // coefficient store: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.exec && doapp)
            coeff_reg[ti] <= COEFF_WIDTH'(req_reg.term_coeff);
        if (cmd.exec && dorem)
            for (int k = 0; k < MAX_TERMS - 1; k++)
                if (TI_W'(k) >= ci) coeff_reg[k] <= coeff_reg[k + 1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= in_item;
        if (cmd.exec)
        begin
            rsp_reg.error_code     <= err;
            rsp_reg.column_one_hot <= doq & onehot;
            rsp_reg.one_hot_row    <= doq ? first_row : 4'd0;
            rsp_reg.removed_coeff  <= dorem ? 16'(signed'(coeff_reg[ci])) : 16'd0;
        end
        if (cmd.sum)
        begin
            rsp_reg.goal_reached <= goal;
            rsp_reg.total_ones   <= 8'(tones + iones);
            rsp_reg.term_ones    <= 8'(tones);
            rsp_reg.terms_left   <= 5'(tc_reg);
        end
    end

    assign out_item = rsp_reg;

    a_tc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tc_reg <= TC_W'(MAX_TERMS))
        else $error("term count overflow");
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && doapp |=> tc_reg == $past(tc_reg) + 1'b1)
        else $error("append did not grow count");
    a_err_nochange: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && err != gpme_pkg::ERR_OK |=> $stable(tc_reg))
        else $error("rejected request changed count");

endmodule

>>> src/gf2_parity_matrix_engine.sv
// gf2_parity_matrix_engine: top level, joins controller, datapath and config register.
// Depends on gpme_pkg, gpme_ctrl, gpme_dp.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------
//  in        | in_valid / in_stall  | in_item  (req_item_t)
//  out       | out_valid / out_stall| out_item (rsp_item_t)
//  cfg       | cfg_valid / cfg_ready| cfg_data (qubits_in_use)
//
// Each transaction steps through accept, execute on the matrix flops,
// popcount/goal summary, then the result register is presented.
// The popcount summary is a separate cycle after the matrix update.
// Reset restores the identity matrix, zero terms and 8 rows in use.
// A stalled result holds the block; no new input is taken until it leaves.
module gf2_parity_matrix_engine #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_TERMS   = 16,
    parameter int COEFF_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  gpme_pkg::req_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output gpme_pkg::rsp_item_t  out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [gpme_pkg::CFG_W-1:0] cfg_data
);

    gpme_pkg::cmd_t cmd;
    logic [gpme_pkg::CFG_W-1:0] rows_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rows_reg <= 4'd8;
        else if (cfg_valid && cfg_ready)
            rows_reg <= cfg_data;
    end

    gpme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    gpme_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_TERMS   (MAX_TERMS),
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_item  (in_item),
        .cfg_rows (rows_reg),
        .out_item (out_item)
    );

endmodule
